FILE: hdl/tga_rle_pixel_decoder_unit_defines.svh
// assertion helpers for the tga rle pixel decoder
`ifndef TGA_RLE_PIXEL_DECODER_UNIT_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_UNIT_DEFINES_SVH

// condition must hold on every clock edge out of reset
`define TGARLE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define TGARLE_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tgarle_pkg.sv
package tgarle_pkg;

    localparam int MAP_ENTRIES_DEFAULT = 256;

    // size codes shared by body pixels and map entries
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_24 = 2'd2;
    localparam logic [1:0] SIZE_32 = 2'd3;

    // register indexes on the apb port
    localparam logic [2:0] REG_PIXEL_SIZE = 3'd0;
    localparam logic [2:0] REG_MAP_SIZE   = 3'd1;
    localparam logic [2:0] REG_RLE_EN     = 3'd2;
    localparam logic [2:0] REG_MAP_EN     = 3'd3;
    localparam logic [2:0] REG_MAP_FIRST  = 3'd4;
    localparam logic [2:0] REG_MAP_LENGTH = 3'd5;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // bytes 0..2 of a gathered word, byte 0 lowest
    function automatic rgb_t split_rgb(input logic [23:0] w, input logic [1:0] sc);
        rgb_t c;
        case (sc)
            SIZE_8: begin
                c.red   = w[7:0];
                c.green = w[7:0];
                c.blue  = w[7:0];
            end
            SIZE_16: begin
                c.red   = {3'b000, w[14:10]};
                c.green = {3'b000, w[9:8], w[7:5]};
                c.blue  = {3'b000, w[4:0]};
            end
            default: begin
                c.red   = w[23:16];
                c.green = w[15:8];
                c.blue  = w[7:0];
            end
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/tgarle_cmap.sv
module tgarle_cmap #(
    parameter int MAP_ENTRIES = tgarle_pkg::MAP_ENTRIES_DEFAULT
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    wr_en,
    input  logic [((MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1)-1:0] wr_addr,
    input  tgarle_pkg::rgb_t                        wr_data,
    input  logic                                    rd_en,
    input  logic [((MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1)-1:0] rd_addr,
    output tgarle_pkg::rgb_t                        rd_data,
    output logic                                    clr_busy
);

    localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_ENTRIES - 1);

    tgarle_pkg::rgb_t mem [MAP_ENTRIES];
    tgarle_pkg::rgb_t rd_data_reg;

    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;
    logic          clr_busy_reg;
    logic          clr_busy_next;

    // clearing sweep after reset, one entry per cycle
    always_comb begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            if (clr_addr_reg == LAST_ADDR) begin
                clr_busy_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end else begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

FILE: hdl/tga_rle_pixel_decoder_unit.sv
// TGA colour-map and RLE pixel decoder. One byte beat per clock on the input stream, tagged by
// tuser as a colour-map byte (0) or an image body byte (1); a pixel result passes from the beat
// that completes it through the pixel stage into the output register, and the pipeline keeps
// taking a beat every cycle while m_axis_tready is high. The single colour map read port is
// read once per completed pixel. After reset the colour map is cleared in a sweep over all
// MAP_ENTRIES entries during which s_axis_tready stays low; APB writes are taken at any time.
// A replicated RLE run gives one result whose repeat_count is the run length.
`include "tga_rle_pixel_decoder_unit_defines.svh"

module tga_rle_pixel_decoder_unit #(
    parameter int MAP_ENTRIES = tgarle_pkg::MAP_ENTRIES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // red, green, blue, alpha, repeat_count
    output logic        m_axis_tuser    // index_error
);

    localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam logic [16:0] MAP_LIMIT = 17'(MAP_ENTRIES);

    // configuration
    logic [1:0]  pix_size_reg;
    logic [1:0]  map_size_reg;
    logic        rle_en_reg;
    logic        map_en_reg;
    logic [13:0] map_first_reg;
    logic [13:0] map_length_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_size_reg   <= tgarle_pkg::SIZE_32;
            map_size_reg   <= tgarle_pkg::SIZE_24;
            rle_en_reg     <= 1'b0;
            map_en_reg     <= 1'b0;
            map_first_reg  <= '0;
            map_length_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                tgarle_pkg::REG_PIXEL_SIZE: pix_size_reg   <= pwdata[1:0];
                tgarle_pkg::REG_MAP_SIZE:   map_size_reg   <= pwdata[1:0];
                tgarle_pkg::REG_RLE_EN:     rle_en_reg     <= pwdata[0];
                tgarle_pkg::REG_MAP_EN:     map_en_reg     <= pwdata[0];
                tgarle_pkg::REG_MAP_FIRST:  map_first_reg  <= pwdata[13:0];
                tgarle_pkg::REG_MAP_LENGTH: map_length_reg <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            tgarle_pkg::REG_PIXEL_SIZE: prdata = {30'd0, pix_size_reg};
            tgarle_pkg::REG_MAP_SIZE:   prdata = {30'd0, map_size_reg};
            tgarle_pkg::REG_RLE_EN:     prdata = {31'd0, rle_en_reg};
            tgarle_pkg::REG_MAP_EN:     prdata = {31'd0, map_en_reg};
            tgarle_pkg::REG_MAP_FIRST:  prdata = {18'd0, map_first_reg};
            tgarle_pkg::REG_MAP_LENGTH: prdata = {18'd0, map_length_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // handshake
    logic clr_busy;
    logic p1_valid_reg;
    logic m_valid_reg;
    logic out_free;
    logic p1_move;
    logic s_fire;
    logic body_fire;
    logic map_fire;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign p1_move       = p1_valid_reg && out_free;
    assign s_axis_tready = !clr_busy && (!p1_valid_reg || out_free);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign body_fire     = s_fire && s_axis_tuser;
    assign map_fire      = s_fire && !s_axis_tuser;

    // body byte gathering and run state
    logic [7:0]  run_left_reg;
    logic [7:0]  run_left_next;
    logic        run_rep_reg;
    logic        run_rep_next;
    logic [7:0]  run_length_reg;
    logic [7:0]  run_length_next;
    logic [1:0]  pix_phase_reg;
    logic [1:0]  pix_phase_next;
    logic [23:0] pix_bytes_reg;
    logic [23:0] pix_bytes_next;

    logic [7:0]  pb0;
    logic [7:0]  pb1;
    logic [7:0]  pb2;
    logic [7:0]  pb3;
    logic [23:0] pix_word;
    logic        hdr_take;
    logic        pix_done;
    logic [15:0] pix_idx;
    logic        idx_ok;
    logic [7:0]  pix_alpha;
    logic [7:0]  pix_rep;
    tgarle_pkg::rgb_t pix_rgb;

    assign pb0 = pix_bytes_reg[7:0]   | ((pix_phase_reg == 2'd0) ? s_axis_tdata : 8'd0);
    assign pb1 = pix_bytes_reg[15:8]  | ((pix_phase_reg == 2'd1) ? s_axis_tdata : 8'd0);
    assign pb2 = pix_bytes_reg[23:16] | ((pix_phase_reg == 2'd2) ? s_axis_tdata : 8'd0);
    assign pb3 = (pix_phase_reg == 2'd3) ? s_axis_tdata : 8'd0;
    assign pix_word = {pb2, pb1, pb0};

    assign hdr_take  = rle_en_reg && (run_left_reg == 8'd0) && (pix_phase_reg == 2'd0);
    assign pix_done  = !hdr_take && (pix_phase_reg >= pix_size_reg);
    assign pix_rgb   = tgarle_pkg::split_rgb(pix_word, pix_size_reg);
    assign pix_alpha = (pix_size_reg == tgarle_pkg::SIZE_32) ? pb3 : 8'hFF;
    assign pix_rep   = (rle_en_reg && run_rep_reg) ? run_length_reg : 8'd1;
    assign idx_ok    = {1'b0, pix_idx} < MAP_LIMIT;

    always_comb begin
        case (pix_size_reg)
            tgarle_pkg::SIZE_8:  pix_idx = {8'd0, pb0};
            tgarle_pkg::SIZE_16: pix_idx = {pb1, pb0};
            default:             pix_idx = 16'd0;
        endcase
    end

    always_comb begin
        run_left_next   = run_left_reg;
        run_rep_next    = run_rep_reg;
        run_length_next = run_length_reg;
        pix_phase_next  = pix_phase_reg;
        pix_bytes_next  = pix_bytes_reg;
        if (body_fire) begin
            if (hdr_take) begin
                run_rep_next    = s_axis_tdata[7];
                run_length_next = {1'b0, s_axis_tdata[6:0]} + 8'd1;
                run_left_next   = {1'b0, s_axis_tdata[6:0]} + 8'd1;
            end else if (!pix_done) begin
                pix_bytes_next = pix_word;
                pix_phase_next = pix_phase_reg + 2'd1;
            end else begin
                pix_bytes_next = '0;
                pix_phase_next = 2'd0;
                if (rle_en_reg) begin
                    if (run_rep_reg) begin
                        run_left_next = 8'd0;
                    end else if (run_left_reg != 8'd0) begin
                        run_left_next = run_left_reg - 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_left_reg   <= '0;
            run_rep_reg    <= 1'b0;
            run_length_reg <= '0;
            pix_phase_reg  <= '0;
            pix_bytes_reg  <= '0;
        end else begin
            run_left_reg   <= run_left_next;
            run_rep_reg    <= run_rep_next;
            run_length_reg <= run_length_next;
            pix_phase_reg  <= pix_phase_next;
            pix_bytes_reg  <= pix_bytes_next;
        end
    end

    // colour map byte gathering
    logic [1:0]  map_phase_reg;
    logic [1:0]  map_phase_next;
    logic [23:0] map_bytes_reg;
    logic [23:0] map_bytes_next;
    logic [13:0] map_count_reg;
    logic [13:0] map_count_next;

    logic [7:0]  mb0;
    logic [7:0]  mb1;
    logic [7:0]  mb2;
    logic [23:0] map_word;
    logic        map_open;
    logic        map_done;
    logic [14:0] map_slot;
    logic        slot_ok;
    logic        map_wr;
    tgarle_pkg::rgb_t map_rgb;

    assign mb0 = map_bytes_reg[7:0]   | ((map_phase_reg == 2'd0) ? s_axis_tdata : 8'd0);
    assign mb1 = map_bytes_reg[15:8]  | ((map_phase_reg == 2'd1) ? s_axis_tdata : 8'd0);
    assign mb2 = map_bytes_reg[23:16] | ((map_phase_reg == 2'd2) ? s_axis_tdata : 8'd0);
    assign map_word = {mb2, mb1, mb0};

    assign map_open = map_count_reg < map_length_reg;
    assign map_done = map_phase_reg >= map_size_reg;
    assign map_slot = {1'b0, map_first_reg} + {1'b0, map_count_reg};
    assign slot_ok  = {2'b00, map_slot} < MAP_LIMIT;
    assign map_rgb  = tgarle_pkg::split_rgb(map_word, map_size_reg);
    assign map_wr   = map_fire && map_open && map_done && slot_ok;

    always_comb begin
        map_phase_next = map_phase_reg;
        map_bytes_next = map_bytes_reg;
        map_count_next = map_count_reg;
        if (map_fire && map_open) begin
            if (!map_done) begin
                map_bytes_next = map_word;
                map_phase_next = map_phase_reg + 2'd1;
            end else begin
                map_bytes_next = '0;
                map_phase_next = 2'd0;
                map_count_next = map_count_reg + 14'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_phase_reg <= '0;
            map_bytes_reg <= '0;
            map_count_reg <= '0;
        end else begin
            map_phase_reg <= map_phase_next;
            map_bytes_reg <= map_bytes_next;
            map_count_reg <= map_count_next;
        end
    end

    // colour map
    logic pix_load;
    tgarle_pkg::rgb_t map_rd_data;

    assign pix_load = body_fire && pix_done;

    tgarle_cmap #(
        .MAP_ENTRIES(MAP_ENTRIES)
    ) u_cmap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (map_wr),
        .wr_addr  (map_slot[AW-1:0]),
        .wr_data  (map_rgb),
        .rd_en    (pix_load),
        .rd_addr  (pix_idx[AW-1:0]),
        .rd_data  (map_rd_data),
        .clr_busy (clr_busy)
    );

    // pixel stage, waits alongside the map read
    logic             p1_valid_next;
    tgarle_pkg::rgb_t p1_rgb_reg;
    logic [7:0]       p1_alpha_reg;
    logic             p1_map_reg;
    logic             p1_err_reg;
    logic [7:0]       p1_rep_reg;

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (pix_load) begin
            p1_valid_next = 1'b1;
        end else if (p1_move) begin
            p1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_load) begin
            p1_rgb_reg   <= pix_rgb;
            p1_alpha_reg <= pix_alpha;
            p1_map_reg   <= map_en_reg && idx_ok;
            p1_err_reg   <= map_en_reg && !idx_ok;
            p1_rep_reg   <= pix_rep;
        end
    end

    // output register
    logic             m_valid_next;
    logic [39:0]      m_data_reg;
    logic [39:0]      m_data_next;
    logic             m_err_reg;
    tgarle_pkg::rgb_t out_rgb;
    logic [7:0]       out_alpha;

    always_comb begin
        if (p1_err_reg) begin
            out_rgb   = '0;
            out_alpha = 8'd0;
        end else if (p1_map_reg) begin
            out_rgb   = map_rd_data;
            out_alpha = 8'hFF;
        end else begin
            out_rgb   = p1_rgb_reg;
            out_alpha = p1_alpha_reg;
        end
    end

    assign m_data_next = {p1_rep_reg, out_alpha, out_rgb.blue, out_rgb.green, out_rgb.red};

    always_comb begin
        m_valid_next = m_valid_reg;
        if (p1_move) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_move) begin
            m_data_reg <= m_data_next;
            m_err_reg  <= p1_err_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_err_reg;

    // checks
    `TGARLE_ASSERT_IMPLIES(a_no_accept_in_clear, clr_busy, !s_axis_tready, "beat taken during map clear")
    `TGARLE_ASSERT_ALWAYS(a_run_left_bounded, run_left_reg <= run_length_reg, "run_left above run length")
    `TGARLE_ASSERT_IMPLIES(a_err_zero_colour, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:0] == 32'd0, "index error with nonzero colour")
    `TGARLE_ASSERT_IMPLIES(a_repeat_nonzero, m_axis_tvalid, m_axis_tdata[39:32] != 8'd0, "zero repeat count")

endmodule
